// ===== rtl/core/csl_pkg.sv =====
// shared types and constants for the cpu status, load select and barrier block
package csl_pkg;

	localparam int CPU_SLOTS_DEF = 8;
	localparam int MAX_IDX_W     = 6;
	localparam int LOAD_W        = 7;
	localparam int TICK_W        = 32;
	localparam int NUM_W         = 8;

	localparam logic [1:0] REQ_ONLINE  = 2'd0;
	localparam logic [1:0] REQ_LOAD    = 2'd1;
	localparam logic [1:0] REQ_BARRIER = 2'd2;
	localparam logic [1:0] REQ_QUERY   = 2'd3;

	// best candidate handed along the row of cells
	typedef struct packed {
		logic                 found;
		logic [LOAD_W-1:0]    load;
		logic [MAX_IDX_W-1:0] idx;
	} carry_t;

endpackage

// ===== rtl/core/cpu_status_load_select_barrier.sv =====
// top level: cpu status table, least-loaded selection row and barrier
// processing order: the multiply and seven-step divide, the table update, the scan along
// the row of cells, then the load of the result register
// flow: one item at a time; in_ready returns only once the result is loaded, later while out_ready is low
// reset: asynchronous, cpu 0 online, loads zero, count one, barrier clear, present count one
module cpu_status_load_select_barrier #(
	parameter int CPU_SLOTS = csl_pkg::CPU_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [csl_pkg::NUM_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 req_type,
	input  logic [7:0]                 cpu,
	input  logic                       go_online,
	input  logic [csl_pkg::TICK_W-1:0] busy_ticks,
	input  logic [csl_pkg::TICK_W-1:0] idle_ticks,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       addr_online,
	output logic [6:0]                 addr_load,
	output logic [2:0]                 chosen_cpu,
	output logic [3:0]                 online_count,
	output logic [7:0]                 cpus_present,
	output logic                       barrier_released,
	output logic [7:0]                 barrier_generation
);
	import csl_pkg::*;

	localparam int IW = (CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1;
	localparam int TW = $clog2(CPU_SLOTS + 1);
	localparam int AW = $clog2(CPU_SLOTS + 2);
	localparam int CW = 7;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]        state_q;
	logic [CW-1:0]     cnt_q;
	logic [1:0]        req_q;
	logic [7:0]        cpu_q;
	logic              go_q;
	logic [NUM_W-1:0]  present_q;
	logic [TW-1:0]     total_q;
	logic [AW-1:0]     arr_q;
	logic [7:0]        gen_q;
	logic              rel_q;
	logic              div_start;
	logic              div_done;
	logic [LOAD_W-1:0] quot;
	logic              valid_cpu;
	logic [IW-1:0]     idx;
	logic [CPU_SLOTS-1:0] flags_v;
	logic [LOAD_W-1:0] loads_v [CPU_SLOTS];
	carry_t            chain [CPU_SLOTS+1];
	logic              upd;
	logic              old_flag;
	logic [AW-1:0]     arr_next;
	logic              out_load;

	logic              out_valid_q;
	logic              o_online_q;
	logic [6:0]        o_load_q;
	logic [2:0]        o_chosen_q;
	logic [3:0]        o_count_q;
	logic [7:0]        o_present_q;
	logic              o_rel_q;
	logic [7:0]        o_gen_q;

	assign valid_cpu = cpu_q < 8'(CPU_SLOTS);
	assign idx       = cpu_q[IW-1:0];
	assign upd       = state_q == ST_UPD;
	assign old_flag  = valid_cpu ? flags_v[idx] : 1'b0;
	assign arr_next  = arr_q + AW'(1);
	assign div_start = (state_q == ST_IDLE) && in_valid;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign chain[0] = '0;

	for (genvar i = 0; i < CPU_SLOTS; i++) begin : g_cell
		csl_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_flag   (upd && req_q == REQ_ONLINE && valid_cpu && idx == IW'(i)),
			.flag_d    (go_q),
			.wr_load   (upd && req_q == REQ_LOAD && valid_cpu && idx == IW'(i)),
			.load_d    (quot),
			.in_scope  (present_q > NUM_W'(i)),
			.carry_in  (chain[i]),
			.flag      (flags_v[i]),
			.load      (loads_v[i]),
			.carry_out (chain[i+1])
		);
	end

	csl_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.busy_ticks (busy_ticks),
		.idle_ticks (idle_ticks),
		.done       (div_done),
		.quot       (quot)
	);

	always_ff @(posedge clk) begin
		if (div_start) begin
			req_q <= req_type;
			cpu_q <= cpu;
			go_q  <= go_online;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			present_q   <= NUM_W'(1);
			total_q     <= TW'(1);
			arr_q       <= '0;
			gen_q       <= '0;
			rel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) present_q <= cfg_data;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_UPD;
				end
				ST_UPD: begin
					rel_q <= 1'b0;
					if (req_q == REQ_ONLINE && valid_cpu && old_flag != go_q) begin
						if (go_q) total_q <= total_q + TW'(1);
						else if (total_q != '0) total_q <= total_q - TW'(1);
					end
					if (req_q == REQ_BARRIER) begin
						// last arrival releases and opens a new generation
						if ({1'b0, arr_next} >= (AW+1)'(total_q)) begin
							arr_q <= '0;
							gen_q <= gen_q + 8'd1;
							rel_q <= 1'b1;
						end else begin
							arr_q <= arr_next;
						end
					end
					cnt_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(CPU_SLOTS)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_online_q  <= old_flag;
			o_load_q    <= valid_cpu ? loads_v[idx] : 7'd0;
			o_chosen_q  <= 3'(chain[CPU_SLOTS].idx);
			o_count_q   <= 4'(total_q);
			o_present_q <= (present_q == '0) ? 8'd1 : present_q;
			o_rel_q     <= rel_q;
			o_gen_q     <= gen_q;
		end
	end

	assign cfg_ready          = 1'b1;
	assign in_ready           = state_q == ST_IDLE;
	assign out_valid          = out_valid_q;
	assign addr_online        = o_online_q;
	assign addr_load          = o_load_q;
	assign chosen_cpu         = o_chosen_q;
	assign online_count       = o_count_q;
	assign cpus_present       = o_present_q;
	assign barrier_released   = o_rel_q;
	assign barrier_generation = o_gen_q;

endmodule

// ===== rtl/core/csl_cell.sv =====
// one cpu slot: online flag, load value and a stage of the least-loaded scan
module csl_cell #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_flag,
	input  logic                        flag_d,
	input  logic                        wr_load,
	input  logic [csl_pkg::LOAD_W-1:0]  load_d,
	input  logic                        in_scope,
	input  csl_pkg::carry_t             carry_in,
	output logic                        flag,
	output logic [csl_pkg::LOAD_W-1:0]  load,
	output csl_pkg::carry_t             carry_out
);
	import csl_pkg::*;

	logic              flag_q;
	logic [LOAD_W-1:0] load_q;
	carry_t            carry_q;
	logic              take;

	assign take = flag_q && in_scope && (!carry_in.found || load_q < carry_in.load);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q  <= (IDX == 0);
			load_q  <= '0;
			carry_q <= '0;
		end else begin
			if (wr_flag) flag_q <= flag_d;
			if (wr_load) load_q <= load_d;
			if (take) begin
				carry_q.found <= 1'b1;
				carry_q.load  <= load_q;
				carry_q.idx   <= MAX_IDX_W'(IDX);
			end else begin
				carry_q <= carry_in;
			end
		end
	end

	assign flag      = flag_q;
	assign load      = load_q;
	assign carry_out = carry_q;

endmodule

// ===== rtl/core/csl_div.sv =====
// load percentage unit: one multiply by 100, then a restoring divide of seven steps
module csl_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [csl_pkg::TICK_W-1:0]  busy_ticks,
	input  logic [csl_pkg::TICK_W-1:0]  idle_ticks,
	output logic                        done,
	output logic [csl_pkg::LOAD_W-1:0]  quot
);
	import csl_pkg::*;

	localparam int REM_W = TICK_W + 7;
	localparam int DSH_W = TICK_W + 1 + LOAD_W - 1;

	logic              run_q;
	logic [2:0]        cnt_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_q;
	logic [DSH_W-1:0]  dsh_q;
	logic [LOAD_W-1:0] quot_q;
	logic              ge;

	assign ge = {1'b0, rem_q} >= {1'b0, DSH_W'(dsh_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'(LOAD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= REM_W'(busy_ticks) * REM_W'(100);
			dsh_q  <= DSH_W'({1'b0, busy_ticks} + {1'b0, idle_ticks} + 33'd1) << (LOAD_W - 1);
			quot_q <= '0;
		end else if (run_q) begin
			if (ge) rem_q <= REM_W'({1'b0, rem_q} - {1'b0, DSH_W'(dsh_q)});
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[LOAD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/core/csl_checker.sv =====
// port-level checks for the cpu status block, bound to the top level
module csl_checker #(
	parameter int CPU_SLOTS = csl_pkg::CPU_SLOTS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       addr_online,
	input logic [6:0] addr_load,
	input logic [3:0] online_count,
	input logic [7:0] cpus_present,
	input logic [7:0] barrier_generation
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(addr_load)
			&& $stable(barrier_generation))
		else $error("result changed while stalled");

	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> addr_load < 7'd100)
		else $error("load out of range");

	a_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cpus_present != 8'd0)
		else $error("cpus present reported as zero");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && addr_online |-> online_count != 4'd0 || CPU_SLOTS > 15)
		else $error("online cpu with zero count");
endmodule

bind cpu_status_load_select_barrier csl_checker #(.CPU_SLOTS(CPU_SLOTS)) u_csl_checker (.*);

// ===== tb/sv/cpu_status_load_select_barrier_tb.sv =====
// testbench for the cpu status table, least-loaded selection and barrier block
`timescale 1ns / 1ps
module cpu_status_load_select_barrier_tb;
	import csl_pkg::*;

	localparam int SLOTS = 8;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic       online;
		logic [6:0] load;
		logic [2:0] chosen;
		logic [3:0] count;
		logic [7:0] present;
		logic       released;
		logic [7:0] gen;
	} status_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [7:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] req_type = 0;
	logic [7:0] cpu = 0;
	logic go_online = 0;
	logic [31:0] busy_ticks = 0;
	logic [31:0] idle_ticks = 0;
	logic out_valid;
	logic out_ready = 0;
	logic addr_online;
	logic [6:0] addr_load;
	logic [2:0] chosen_cpu;
	logic [3:0] online_count;
	logic [7:0] cpus_present;
	logic barrier_released;
	logic [7:0] barrier_generation;

	cpu_status_load_select_barrier dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .cpu(cpu),
		.go_online(go_online), .busy_ticks(busy_ticks), .idle_ticks(idle_ticks),
		.out_valid(out_valid), .out_ready(out_ready), .addr_online(addr_online),
		.addr_load(addr_load), .chosen_cpu(chosen_cpu), .online_count(online_count),
		.cpus_present(cpus_present), .barrier_released(barrier_released),
		.barrier_generation(barrier_generation)
	);

	// mirror of the block's state
	logic       m_online[SLOTS];
	logic [6:0] m_load[SLOTS];
	logic [3:0] m_total;
	logic [3:0] m_arrivals;
	logic [7:0] m_gen;
	logic [7:0] m_num;

	status_t expected_status[$];
	int failures = 0;
	int items_sent = 0;
	int results_seen = 0;
	int releases_seen = 0;
	int cycles = 0;

	initial forever #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL cpu_status_load_select_barrier");
			$finish;
		end
	end

	function automatic logic [2:0] least_loaded();
		int lim;
		int best;
		int best_load;
		lim = (m_num < SLOTS) ? m_num : SLOTS;
		best = 0;
		best_load = 1000;
		for (int i = 0; i < lim; i++)
			if (m_online[i] && m_load[i] < best_load) begin
				best_load = m_load[i];
				best = i;
			end
		return best[2:0];
	endfunction

	function automatic status_t apply_request(logic [1:0] rt, logic [7:0] c, logic g,
			logic [31:0] b, logic [31:0] idl);
		status_t s;
		logic ok;
		logic [63:0] num;
		logic [63:0] den;
		ok = c < SLOTS;
		s.released = 1'b0;
		if (rt == REQ_ONLINE && ok) begin
			if (m_online[c] != g) begin
				m_online[c] = g;
				if (g) m_total = m_total + 4'd1;
				else if (m_total > 0) m_total = m_total - 4'd1;
			end
		end else if (rt == REQ_LOAD && ok) begin
			num = 64'(b) * 64'd100;
			den = 64'(b) + 64'(idl) + 64'd1;
			m_load[c] = 7'(num / den);
		end else if (rt == REQ_BARRIER) begin
			m_arrivals = m_arrivals + 4'd1;
			if (m_arrivals >= m_total) begin
				m_arrivals = '0;
				m_gen = m_gen + 8'd1;
				s.released = 1'b1;
			end
		end
		s.online = ok ? m_online[c] : 1'b0;
		s.load = ok ? m_load[c] : 7'd0;
		s.chosen = least_loaded();
		s.count = m_total;
		s.present = (m_num == 0) ? 8'd1 : m_num;
		s.gen = m_gen;
		return s;
	endfunction

	// leaves valid high after the accepting edge; an idle wait drops it, the next call replaces the request
	task automatic send_request(logic [1:0] rt, logic [7:0] c, logic g,
			logic [31:0] b, logic [31:0] idl);
		int gap;
		gap = $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		req_type <= rt;
		cpu <= c;
		go_online <= g;
		busy_ticks <= b;
		idle_ticks <= idl;
		in_valid <= 1;
		expected_status.push_back(apply_request(rt, c, g, b, idl));
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 0;
		while (expected_status.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_cpu_count(logic [7:0] v);
		wait_idle();
		cfg_data <= v;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		m_num = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// result checker with random back-pressure
	initial begin
		status_t e;
		int stall;
		forever begin
			@(negedge clk);
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			results_seen++;
			if (barrier_released) releases_seen++;
			if (expected_status.size() == 0) begin
				$error("result with nothing expected");
				failures++;
			end else begin
				e = expected_status.pop_front();
				if (addr_online !== e.online) begin
					$error("addr_online exp %0d got %0d", e.online, addr_online); failures++;
				end
				if (addr_load !== e.load) begin
					$error("addr_load exp %0d got %0d", e.load, addr_load); failures++;
				end
				if (chosen_cpu !== e.chosen) begin
					$error("chosen_cpu exp %0d got %0d", e.chosen, chosen_cpu); failures++;
				end
				if (online_count !== e.count) begin
					$error("online_count exp %0d got %0d", e.count, online_count); failures++;
				end
				if (cpus_present !== e.present) begin
					$error("cpus_present exp %0d got %0d", e.present, cpus_present);
					failures++;
				end
				if (barrier_released !== e.released) begin
					$error("barrier_released exp %0d got %0d", e.released, barrier_released);
					failures++;
				end
				if (barrier_generation !== e.gen) begin
					$error("barrier_generation exp %0d got %0d", e.gen, barrier_generation);
					failures++;
				end
			end
		end
	end

	task automatic test_directed();
		send_request(REQ_QUERY, 0, 0, 0, 0);
		send_request(REQ_QUERY, 8'hff, 1, '1, '1);
		send_request(REQ_LOAD, 0, 0, '1, '1);
		send_request(REQ_LOAD, 0, 0, '1, 0);
		send_request(REQ_LOAD, 0, 0, 0, '1);
		send_request(REQ_LOAD, 9, 0, 100, 0);
		send_request(REQ_ONLINE, 0, 1, 0, 0);
		send_request(REQ_ONLINE, 0, 0, 0, 0);
		send_request(REQ_ONLINE, 0, 0, 0, 0);
		// no cpu online: first arrival releases
		send_request(REQ_BARRIER, 3, 0, 0, 0);
		send_request(REQ_ONLINE, 8, 1, 0, 0);
		send_request(REQ_ONLINE, 0, 1, 0, 0);
		send_request(REQ_ONLINE, 7, 1, 0, 0);
		send_request(REQ_LOAD, 7, 0, 1, 1);
		send_request(REQ_BARRIER, 0, 0, 0, 0);
		send_request(REQ_BARRIER, 200, 1, 0, 0);
		write_cpu_count(8'd255);
		send_request(REQ_LOAD, 0, 0, 3, 1);
		send_request(REQ_QUERY, 7, 0, 0, 0);
		write_cpu_count(8'd0);
		send_request(REQ_QUERY, 7, 0, 0, 0);
		write_cpu_count(8'd8);
		send_request(REQ_QUERY, 1, 0, 0, 0);
	endtask

	task automatic test_random(int n);
		logic [1:0] rt;
		logic [7:0] c;
		logic [31:0] b;
		logic [31:0] idl;
		for (int k = 0; k < n; k++) begin
			if (k % 200 == 199) write_cpu_count($urandom_range(0, 3) == 0 ?
				8'($urandom) : 8'($urandom_range(0, 9)));
			rt = 2'($urandom_range(0, 3));
			c = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0: begin b = $urandom; idl = $urandom; end
				1: begin b = $urandom_range(0, 1000); idl = $urandom_range(0, 1000); end
				2: begin b = '1; idl = $urandom_range(0, 3); end
				default: begin b = $urandom_range(0, 3); idl = '1; end
			endcase
			send_request(rt, c, 1'($urandom_range(0, 1)), b, idl);
		end
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			m_online[i] = (i == 0);
			m_load[i] = 0;
		end
		m_total = 1;
		m_arrivals = 0;
		m_gen = 0;
		m_num = 1;
		repeat (5) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		test_directed();
		test_random(950);
		write_cpu_count(8'd1);
		send_request(REQ_BARRIER, 0, 0, 0, 0);
		wait_idle();
		$display("sent %0d items, checked %0d results, %0d barrier releases",
			items_sent, results_seen, releases_seen);
		if (failures == 0 && expected_status.size() == 0)
			$display("PASS cpu_status_load_select_barrier");
		else
			$display("FAIL cpu_status_load_select_barrier");
		$finish;
	end

endmodule
